FILE: hdl/dvrt_pkg.sv
// package for the distance vector route table
// holds field widths, mode, status and register codes, and the item structs
// no dependencies
package dvrt_pkg;

    localparam int NODE_W     = 4;
    localparam int COST_W     = 8;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NBR_MAX    = 3;

    localparam int DEF_NODE_COUNT     = 16;
    localparam int DEF_NEIGHBOR_SLOTS = 3;
    localparam int DEF_INFINITE_COST  = 255;

    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_IMPROVED = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_C   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_A  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_B  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_C  = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] dest_node;
        logic [COST_W-1:0] reported_cost;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] out_node;
        logic [COST_W-1:0] out_cost;
        logic [NODE_W-1:0] out_next_hop;
        logic [STAT_W-1:0] status;
        logic              is_last;
    } t_out_item;

endpackage

FILE: hdl/distance_vector_route_table.sv
// update or lookup: result registered from S_EVAL when output is free; input waits till then
// dump: min(NODE_COUNT,16) results, one per cycle unless the output stalls, set by the
// single table read port; the next input is taken the cycle after the last result is loaded
// reset (synchronous): registers go to ids 0 and link costs 255, the per-entry valid bits
// clear at once so all but the own node read as infinity with next hop 0; no clearing pass
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int NODE_COUNT     = DEF_NODE_COUNT,
    parameter int NEIGHBOR_SLOTS = DEF_NEIGHBOR_SLOTS,
    parameter int INFINITE_COST  = DEF_INFINITE_COST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data
);

    localparam int DEPTH = (NODE_COUNT < 16) ? NODE_COUNT : 16;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COST_W-1:0] INF      = COST_W'(INFINITE_COST);
    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    // configuration registers
    logic [NODE_W-1:0] r_my_id;
    logic [NODE_W-1:0] r_nbr_id  [NBR_MAX];
    logic [COST_W-1:0] r_link_cost [NBR_MAX];

    // route table: cost and next hop per entry
    logic [COST_W+NODE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    logic [COST_W+NODE_W-1:0] r_rd_ent;
    logic                     r_rd_vld;

    logic [1:0]        r_state, n_state;
    t_in_item          r_item;
    logic [NODE_W-1:0] r_dump_idx, n_dump_idx;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [NODE_W-1:0] dump_next;

    logic [NODE_W-1:0] view_node;
    logic              view_in_range;
    logic [COST_W-1:0] view_cost;
    logic [NODE_W-1:0] view_hop;
    logic [STAT_W-1:0] view_stat;

    logic              slot_hit;
    logic [COST_W-1:0] slot_cost;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] sat_cost;
    logic              improve;
    logic [STAT_W-1:0] upd_stat;

    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign dump_next = r_dump_idx + 4'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id <= '0;
            for (int i = 0; i < NBR_MAX; i++) begin
                r_nbr_id[i]    <= '0;
                r_link_cost[i] <= 8'd255;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MY_NODE: r_my_id        <= i_cfg_data[NODE_W-1:0];
                CFG_NBR_A:   r_nbr_id[0]    <= i_cfg_data[NODE_W-1:0];
                CFG_NBR_B:   r_nbr_id[1]    <= i_cfg_data[NODE_W-1:0];
                CFG_NBR_C:   r_nbr_id[2]    <= i_cfg_data[NODE_W-1:0];
                CFG_COST_A:  r_link_cost[0] <= i_cfg_data[COST_W-1:0];
                CFG_COST_B:  r_link_cost[1] <= i_cfg_data[COST_W-1:0];
                CFG_COST_C:  r_link_cost[2] <= i_cfg_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // read port address: reads happen only in idle and dump, writes only in eval
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_data.dest_node[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                rd_en = in_acc;
                if (i_data.mode == MODE_DUMP) begin
                    rd_addr = '0;
                end
            end
            S_DUMP: begin
                rd_en   = out_free;
                rd_addr = dump_next[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {sat_cost, r_item.sender};
        end
        if (rd_en) begin
            r_rd_ent <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // view of one entry, with the own node and out of range handled here
    always_comb begin
        view_node     = (r_state == S_DUMP) ? r_dump_idx : r_item.dest_node;
        view_in_range = (int'(view_node) < NODE_COUNT);
        if (!view_in_range) begin
            view_cost = INF;
            view_hop  = '0;
        end else if (view_node == r_my_id) begin
            view_cost = '0;
            view_hop  = r_my_id;
        end else if (r_rd_vld) begin
            view_cost = r_rd_ent[COST_W+NODE_W-1:NODE_W];
            view_hop  = r_rd_ent[NODE_W-1:0];
        end else begin
            view_cost = INF;
            view_hop  = '0;
        end
        view_stat = (!view_in_range || view_cost >= INF) ? ST_NO_ROUTE : ST_OK;
    end

    // relaxation of one update entry
    always_comb begin
        slot_hit  = 1'b0;
        slot_cost = '0;
        // walk backward so the first matching slot wins
        for (int i = NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
            if (r_link_cost[i] < INF && r_nbr_id[i] == r_item.sender) begin
                slot_hit  = 1'b1;
                slot_cost = r_link_cost[i];
            end
        end
        sum = {1'b0, r_item.reported_cost} + {1'b0, slot_cost};
        if (r_item.reported_cost >= INF || sum >= {1'b0, INF}) begin
            sat_cost = INF;
        end else begin
            sat_cost = sum[COST_W-1:0];
        end
        improve = view_in_range && slot_hit && (r_item.dest_node != r_my_id)
                  && (sat_cost < view_cost);
        priority if (!view_in_range) begin
            upd_stat = ST_NO_ROUTE;
        end else if (!slot_hit) begin
            upd_stat = ST_UNKNOWN;
        end else if (improve) begin
            upd_stat = ST_IMPROVED;
        end else begin
            upd_stat = ST_OK;
        end
    end

    assign wr_en   = (r_state == S_EVAL) && out_free && (r_item.mode == MODE_UPDATE) && improve;
    assign wr_addr = r_item.dest_node[AW-1:0];

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_data.mode == MODE_DUMP) begin
                        n_state    = S_DUMP;
                        n_dump_idx = '0;
                    end else if (i_data.mode == MODE_UPDATE || i_data.mode == MODE_LOOKUP) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state            = S_IDLE;
                    n_out_valid        = 1'b1;
                    n_out.out_node     = r_item.dest_node;
                    n_out.is_last      = 1'b1;
                    if (r_item.mode == MODE_UPDATE && improve) begin
                        n_out.out_cost     = sat_cost;
                        n_out.out_next_hop = r_item.sender;
                    end else begin
                        n_out.out_cost     = view_cost;
                        n_out.out_next_hop = view_hop;
                    end
                    n_out.status = (r_item.mode == MODE_UPDATE) ? upd_stat : view_stat;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.out_node     = r_dump_idx;
                    n_out.out_cost     = view_cost;
                    n_out.out_next_hop = view_hop;
                    n_out.status       = view_stat;
                    n_out.is_last      = (r_dump_idx == LAST_IDX);
                    if (r_dump_idx == LAST_IDX) begin
                        n_state    = S_IDLE;
                        n_dump_idx = '0;
                    end else begin
                        n_dump_idx = dump_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_item <= i_data;
        end
    end

endmodule
